// ===== hdl/ucfp_pkg.sv =====
// shared types, codes and constants of the uplink command frame parser
// no dependencies; used by uplink_command_frame_parser and its checker

package ucfp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 20;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] SUM_INIT   = 8'(HDR_FIRST + HDR_SECOND);

    localparam logic [7:0] FN_SET1     = 8'h01;
    localparam logic [7:0] FN_SET2     = 8'h02;
    localparam logic [7:0] FN_CONTROL  = 8'h03;
    localparam logic [7:0] FN_GAIN_LO  = 8'h10;
    localparam logic [7:0] FN_GAIN_HI  = 8'h12;

    localparam logic [7:0] CMD_ACC_CAL  = 8'h01;
    localparam logic [7:0] CMD_GYRO_CAL = 8'h02;
    localparam logic [7:0] CMD_MAG_CAL  = 8'h04;
    localparam logic [7:0] CMD_LOCK     = 8'hA0;
    localparam logic [7:0] CMD_UNLOCK   = 8'hA1;
    localparam logic [7:0] CMD_GAIN_REQ = 8'h01;
    localparam logic [7:0] CMD_VER_REQ  = 8'hA0;

    localparam logic [3:0] EV_CHECK_ERR   = 4'd0;
    localparam logic [3:0] EV_UNKNOWN_CMD = 4'd1;
    localparam logic [3:0] EV_ACC_CAL     = 4'd2;
    localparam logic [3:0] EV_GYRO_CAL    = 4'd3;
    localparam logic [3:0] EV_MAG_CAL     = 4'd4;
    localparam logic [3:0] EV_LOCK        = 4'd5;
    localparam logic [3:0] EV_UNLOCK      = 4'd6;
    localparam logic [3:0] EV_GAIN_REQ    = 4'd7;
    localparam logic [3:0] EV_VER_REQ     = 4'd8;
    localparam logic [3:0] EV_TARGET      = 4'd9;
    localparam logic [3:0] EV_GAIN_VAL    = 4'd10;
    localparam logic [3:0] EV_UNKNOWN_FN  = 4'd11;

    localparam logic [3:0] TARGET_COUNT = 4'd4;
    localparam logic [3:0] GAIN_COUNT   = 4'd9;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        JOB_ERR     = 3'd0,
        JOB_UNK_FN  = 3'd1,
        JOB_SET1    = 3'd2,
        JOB_SET2    = 3'd3,
        JOB_CONTROL = 3'd4,
        JOB_GAIN    = 3'd5
    } job_kind_t;

    function automatic logic [4:0] fixed_length(input logic [7:0] f);
        logic [4:0] n;
        n = 5'd0;
        if (f == FN_SET1 || f == FN_SET2) n = 5'd1;
        else if (f == FN_CONTROL) n = 5'd20;
        else if (f >= FN_GAIN_LO && f <= FN_GAIN_HI) n = 5'd18;
        return n;
    endfunction

endpackage

// ===== hdl/uplink_command_frame_parser.sv =====
// uplink command frame parser: header sync, length and checksum check, decode
// payload kept in a synchronous memory; depends on ucfp_pkg
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid / s_tready     | s_tdata = rx_byte
//  m_      | out | m_tvalid / m_tready     | m_tuser = event_res, m_tdata, m_tlast = last
//
// one byte is taken per cycle when s_tready is high; results of a frame go through the
// job register, payload memory read and output register, one per cycle unless stalled
// while the payload of a finished frame is still being read out, the input
// stalls on function, payload and checksum bytes; header and length bytes keep flowing
// aresetn (synchronous) returns the parser to header search and sets the lock state
// the payload memory needs no clearing pass

module uplink_command_frame_parser #(
    parameter int PAYLOAD_DEPTH = ucfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] bank, [5:2] item_index, [21:6] value,
                                   // [22] reply_needed, [30:23] reply_code,
                                   // [38:31] reply_check, [39] locked
    output logic [3:0]  m_tuser,   // [3:0] event_res
    output logic        m_tlast    // last
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    // parser state
    ucfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] func_reg, func_next;
    logic [7:0] len_reg, len_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [7:0] sum_reg, sum_next;
    logic       lock_reg, lock_next;

    // readout job
    logic                  job_valid_reg, job_valid_next;
    ucfp_pkg::job_kind_t   job_kind_reg, job_kind_next;
    logic [7:0]            job_func_reg, job_func_next;
    logic [7:0]            job_chk_reg, job_chk_next;
    logic [3:0]            job_idx_reg, job_idx_next;

    // read stage
    logic                  st1_valid_reg, st1_valid_next;
    ucfp_pkg::job_kind_t   st1_kind_reg, st1_kind_next;
    logic [7:0]            st1_func_reg, st1_func_next;
    logic [7:0]            st1_chk_reg, st1_chk_next;
    logic [3:0]            st1_idx_reg, st1_idx_next;
    logic                  st1_last_reg, st1_last_next;
    logic [AW-1:0]         st1_addr_reg, st1_addr_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;
    logic [3:0]  m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    logic [7:0] mem [PAYLOAD_DEPTH];
    logic [7:0] rd0_reg, rd1_reg;
    logic       mem_we;

    logic       s_accept, busy, out_free, st1_adv, st1_load_ok, issue;
    logic       job_load, job_last;
    logic [4:0] need, cnt_inc;
    logic [3:0] job_count;
    logic [7:0] b;

    assign b        = s_tdata;
    assign busy     = job_valid_reg || st1_valid_reg;
    assign s_tready = !(busy && (phase_reg == ucfp_pkg::PH_FUNC ||
                                 phase_reg == ucfp_pkg::PH_DATA ||
                                 phase_reg == ucfp_pkg::PH_CHECK));
    assign s_accept = s_tvalid && s_tready;
    assign need     = ucfp_pkg::fixed_length(func_reg);
    assign cnt_inc  = cnt_reg + 5'd1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (s_accept) begin
            case (phase_reg)
                ucfp_pkg::PH_SYNC2: begin
                    phase_next = (b == ucfp_pkg::HDR_SECOND) ? ucfp_pkg::PH_FUNC
                                                             : ucfp_pkg::PH_SYNC1;
                end
                ucfp_pkg::PH_FUNC: begin
                    phase_next = (ucfp_pkg::fixed_length(b) == 5'd0) ? ucfp_pkg::PH_SYNC1
                                                                     : ucfp_pkg::PH_LEN;
                end
                ucfp_pkg::PH_LEN:   phase_next = ucfp_pkg::PH_DATA;
                ucfp_pkg::PH_DATA: begin
                    phase_next = (cnt_inc >= need) ? ucfp_pkg::PH_CHECK : ucfp_pkg::PH_DATA;
                end
                ucfp_pkg::PH_CHECK: phase_next = ucfp_pkg::PH_SYNC1;
                default: begin
                    phase_next = (b == ucfp_pkg::HDR_FIRST) ? ucfp_pkg::PH_SYNC2
                                                            : ucfp_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    // parser datapath and job creation
    always_comb begin
        func_next     = func_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        mem_we        = 1'b0;
        job_load      = 1'b0;
        job_kind_next = job_kind_reg;
        job_func_next = job_func_reg;
        job_chk_next  = job_chk_reg;
        if (s_accept) begin
            case (phase_reg)
                ucfp_pkg::PH_SYNC2: begin
                    if (b == ucfp_pkg::HDR_SECOND) sum_next = ucfp_pkg::SUM_INIT;
                end
                ucfp_pkg::PH_FUNC: begin
                    func_next = b;
                    if (ucfp_pkg::fixed_length(b) == 5'd0) begin
                        job_load      = 1'b1;
                        job_kind_next = ucfp_pkg::JOB_UNK_FN;
                    end else begin
                        sum_next = sum_reg + b;
                    end
                end
                ucfp_pkg::PH_LEN: begin
                    len_next = b;
                    sum_next = sum_reg + b;
                    cnt_next = 5'd0;
                end
                ucfp_pkg::PH_DATA: begin
                    mem_we   = 32'(cnt_reg) < PAYLOAD_DEPTH;
                    sum_next = sum_reg + b;
                    cnt_next = cnt_inc;
                end
                ucfp_pkg::PH_CHECK: begin
                    job_load      = 1'b1;
                    job_func_next = func_reg;
                    job_chk_next  = b;
                    if (need == 5'd0 || len_reg != {3'd0, need} || sum_reg != b)
                        job_kind_next = ucfp_pkg::JOB_ERR;
                    else if (func_reg == ucfp_pkg::FN_SET1)
                        job_kind_next = ucfp_pkg::JOB_SET1;
                    else if (func_reg == ucfp_pkg::FN_SET2)
                        job_kind_next = ucfp_pkg::JOB_SET2;
                    else if (func_reg == ucfp_pkg::FN_CONTROL)
                        job_kind_next = ucfp_pkg::JOB_CONTROL;
                    else
                        job_kind_next = ucfp_pkg::JOB_GAIN;
                end
                default: ;
            endcase
        end
    end

    // readout sequencing: job -> read stage -> output register
    assign out_free    = !m_valid_reg || m_tready;
    assign st1_adv     = st1_valid_reg && out_free;
    assign st1_load_ok = !st1_valid_reg || out_free;
    assign issue       = job_valid_reg && st1_load_ok;

    always_comb begin
        case (job_kind_reg)
            ucfp_pkg::JOB_CONTROL: job_count = ucfp_pkg::TARGET_COUNT;
            ucfp_pkg::JOB_GAIN:    job_count = ucfp_pkg::GAIN_COUNT;
            default:               job_count = 4'd1;
        endcase
    end
    assign job_last = (job_idx_reg == job_count - 4'd1);

    always_comb begin
        job_valid_next = job_valid_reg && !(issue && job_last);
        job_idx_next   = job_idx_reg;
        if (issue) job_idx_next = job_idx_reg + 4'd1;
        if (job_load) begin
            job_valid_next = 1'b1;
            job_idx_next   = 4'd0;
        end
    end

    always_comb begin
        st1_valid_next = st1_valid_reg && !st1_adv;
        st1_kind_next  = st1_kind_reg;
        st1_func_next  = st1_func_reg;
        st1_chk_next   = st1_chk_reg;
        st1_idx_next   = st1_idx_reg;
        st1_last_next  = st1_last_reg;
        st1_addr_next  = st1_addr_reg;
        if (issue) begin
            st1_valid_next = 1'b1;
            st1_kind_next  = job_kind_reg;
            st1_func_next  = job_func_reg;
            st1_chk_next   = job_chk_reg;
            st1_idx_next   = job_idx_reg;
            st1_last_next  = job_last;
            st1_addr_next  = AW'({job_idx_reg, 1'b0});
        end
    end

    // result formation from read data
    always_comb begin
        logic [3:0]  ev;
        logic [1:0]  bank;
        logic [3:0]  idx;
        logic [15:0] val;
        logic        rn;
        logic [7:0]  rc;
        logic [7:0]  rck;
        ev        = ucfp_pkg::EV_CHECK_ERR;
        bank      = 2'd0;
        idx       = 4'd0;
        val       = 16'd0;
        rn        = 1'b0;
        rc        = 8'd0;
        rck       = 8'd0;
        lock_next = lock_reg;
        case (st1_kind_reg)
            ucfp_pkg::JOB_UNK_FN: ev = ucfp_pkg::EV_UNKNOWN_FN;
            ucfp_pkg::JOB_SET1: begin
                case (rd0_reg)
                    ucfp_pkg::CMD_ACC_CAL:  ev = ucfp_pkg::EV_ACC_CAL;
                    ucfp_pkg::CMD_GYRO_CAL: ev = ucfp_pkg::EV_GYRO_CAL;
                    ucfp_pkg::CMD_MAG_CAL:  ev = ucfp_pkg::EV_MAG_CAL;
                    ucfp_pkg::CMD_LOCK: begin
                        ev        = ucfp_pkg::EV_LOCK;
                        lock_next = 1'b1;
                        rn        = 1'b1;
                        rc        = st1_func_reg;
                        rck       = st1_chk_reg;
                    end
                    ucfp_pkg::CMD_UNLOCK: begin
                        ev        = ucfp_pkg::EV_UNLOCK;
                        lock_next = 1'b0;
                        rn        = 1'b1;
                        rc        = st1_func_reg;
                        rck       = st1_chk_reg;
                    end
                    default: ev = ucfp_pkg::EV_UNKNOWN_CMD;
                endcase
            end
            ucfp_pkg::JOB_SET2: begin
                if (rd0_reg == ucfp_pkg::CMD_GAIN_REQ)     ev = ucfp_pkg::EV_GAIN_REQ;
                else if (rd0_reg == ucfp_pkg::CMD_VER_REQ) ev = ucfp_pkg::EV_VER_REQ;
                else                                       ev = ucfp_pkg::EV_UNKNOWN_CMD;
            end
            ucfp_pkg::JOB_CONTROL: begin
                ev  = ucfp_pkg::EV_TARGET;
                idx = st1_idx_reg;
                val = {rd0_reg, rd1_reg};
            end
            ucfp_pkg::JOB_GAIN: begin
                ev   = ucfp_pkg::EV_GAIN_VAL;
                bank = 2'(st1_func_reg - ucfp_pkg::FN_GAIN_LO);
                idx  = st1_idx_reg;
                val  = {rd0_reg, rd1_reg};
                if (st1_last_reg) begin
                    rn  = 1'b1;
                    rc  = st1_func_reg;
                    rck = st1_chk_reg;
                end
            end
            default: ev = ucfp_pkg::EV_CHECK_ERR;
        endcase
        if (!st1_adv) lock_next = lock_reg;

        m_valid_next = st1_adv || (m_valid_reg && !m_tready);
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (st1_adv) begin
            m_data_next = {lock_next, rck, rc, rn, val, idx, bank};
            m_user_next = ev;
            m_last_next = st1_last_reg;
        end
    end

    // payload memory, read address held while the read stage stalls
    always_ff @(posedge aclk) begin
        if (mem_we) mem[cnt_reg[AW-1:0]] <= b;
        rd0_reg <= mem[st1_addr_next];
        rd1_reg <= mem[st1_addr_next + AW'(1)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ucfp_pkg::PH_SYNC1;
            func_reg      <= 8'd0;
            len_reg       <= 8'd0;
            cnt_reg       <= 5'd0;
            sum_reg       <= 8'd0;
            lock_reg      <= 1'b1;
            job_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            func_reg      <= func_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            lock_reg      <= lock_next;
            job_valid_reg <= job_valid_next;
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_kind_reg <= job_kind_next;
        job_func_reg <= job_func_next;
        job_chk_reg  <= job_chk_next;
        job_idx_reg  <= job_idx_next;
        st1_kind_reg <= st1_kind_next;
        st1_func_reg <= st1_func_next;
        st1_chk_reg  <= st1_chk_next;
        st1_idx_reg  <= st1_idx_next;
        st1_last_reg <= st1_last_next;
        st1_addr_reg <= st1_addr_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/ucfp_checker.sv =====
// port-level checks for uplink_command_frame_parser, attached by bind
// depends on ucfp_pkg

module ucfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // a waiting input beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("waiting input beat changed");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // only target and gain frames give more than one beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == ucfp_pkg::EV_TARGET
                                 || m_tuser == ucfp_pkg::EV_GAIN_VAL)
        else $error("multi-beat result of a single-beat event");

    // a gain beat that is not last is followed by the next gain index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tuser == ucfp_pkg::EV_GAIN_VAL
        ##1 m_tvalid |-> m_tdata[5:2] == $past(m_tdata[5:2]) + 4'd1)
        else $error("gain index out of sequence");

endmodule

bind uplink_command_frame_parser ucfp_checker u_ucfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/uplink_command_frame_parser_tb.sv =====
// self-checking testbench for uplink_command_frame_parser: byte stream in, frame events out
// a scoreboard class tracks header/length/checksum parsing and lock state to predict results
// depends on ucfp_pkg and the parser rtl

module uplink_command_frame_parser_tb;

    localparam int CYCLE_LIMIT = 300000;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [3:0]  ev;
        logic [1:0]  bank;
        logic [3:0]  item_idx;
        logic [15:0] value;
        logic        last;
        logic        reply_needed;
        logic [7:0]  reply_code;
        logic [7:0]  reply_check;
        logic        locked;
    } frame_result_t;

    class frame_scoreboard;
        ucfp_pkg::phase_t phase;
        logic [7:0]    func;
        logic [7:0]    len_field;
        logic [7:0]    sum;
        int            count;
        logic [7:0]    payload[ucfp_pkg::PAYLOAD_DEPTH_DEF];
        logic          locked;
        frame_result_t expected_results[$];
        int            errors;

        function new();
            phase = ucfp_pkg::PH_SYNC1;
            func = '0;
            len_field = '0;
            sum = '0;
            count = 0;
            locked = 1'b1;
            errors = 0;
        endfunction

        static function int payload_len(logic [7:0] f);
            case (f)
                ucfp_pkg::FN_SET1, ucfp_pkg::FN_SET2: return 1;
                ucfp_pkg::FN_CONTROL: return 20;
                default: return (f >= ucfp_pkg::FN_GAIN_LO && f <= ucfp_pkg::FN_GAIN_HI)
                                ? 18 : 0;
            endcase
        endfunction

        function void push(logic [3:0] ev, logic [1:0] bank, logic [3:0] idx, logic [15:0] val,
                           logic last, logic rn, logic [7:0] rc, logic [7:0] rck);
            frame_result_t r;
            r.ev = ev;
            r.bank = bank;
            r.item_idx = idx;
            r.value = val;
            r.last = last;
            r.reply_needed = rn;
            r.reply_code = rc;
            r.reply_check = rck;
            r.locked = locked;
            expected_results.push_back(r);
        endfunction

        function void decode_frame(logic [7:0] chk);
            int   need;
            logic [7:0] cmd;
            need = payload_len(func);
            cmd = payload[0];
            if (need == 0 || int'(len_field) != need || sum != chk) begin
                push(ucfp_pkg::EV_CHECK_ERR, 0, 0, 0, 1, 0, 0, 0);
            end else if (func == ucfp_pkg::FN_SET1) begin
                case (cmd)
                    ucfp_pkg::CMD_ACC_CAL:  push(ucfp_pkg::EV_ACC_CAL, 0, 0, 0, 1, 0, 0, 0);
                    ucfp_pkg::CMD_GYRO_CAL: push(ucfp_pkg::EV_GYRO_CAL, 0, 0, 0, 1, 0, 0, 0);
                    ucfp_pkg::CMD_MAG_CAL:  push(ucfp_pkg::EV_MAG_CAL, 0, 0, 0, 1, 0, 0, 0);
                    ucfp_pkg::CMD_LOCK: begin
                        locked = 1'b1;
                        push(ucfp_pkg::EV_LOCK, 0, 0, 0, 1, 1, func, chk);
                    end
                    ucfp_pkg::CMD_UNLOCK: begin
                        locked = 1'b0;
                        push(ucfp_pkg::EV_UNLOCK, 0, 0, 0, 1, 1, func, chk);
                    end
                    default: push(ucfp_pkg::EV_UNKNOWN_CMD, 0, 0, 0, 1, 0, 0, 0);
                endcase
            end else if (func == ucfp_pkg::FN_SET2) begin
                if (cmd == ucfp_pkg::CMD_GAIN_REQ)
                    push(ucfp_pkg::EV_GAIN_REQ, 0, 0, 0, 1, 0, 0, 0);
                else if (cmd == ucfp_pkg::CMD_VER_REQ)
                    push(ucfp_pkg::EV_VER_REQ, 0, 0, 0, 1, 0, 0, 0);
                else
                    push(ucfp_pkg::EV_UNKNOWN_CMD, 0, 0, 0, 1, 0, 0, 0);
            end else if (func == ucfp_pkg::FN_CONTROL) begin
                for (int i = 0; i < int'(ucfp_pkg::TARGET_COUNT); i++)
                    push(ucfp_pkg::EV_TARGET, 0, 4'(i), {payload[2*i], payload[2*i+1]},
                         i == int'(ucfp_pkg::TARGET_COUNT) - 1, 0, 0, 0);
            end else begin
                for (int i = 0; i < int'(ucfp_pkg::GAIN_COUNT); i++) begin
                    if (i == int'(ucfp_pkg::GAIN_COUNT) - 1)
                        push(ucfp_pkg::EV_GAIN_VAL, 2'(func - ucfp_pkg::FN_GAIN_LO), 4'(i),
                             {payload[2*i], payload[2*i+1]}, 1, 1, func, chk);
                    else
                        push(ucfp_pkg::EV_GAIN_VAL, 2'(func - ucfp_pkg::FN_GAIN_LO), 4'(i),
                             {payload[2*i], payload[2*i+1]}, 0, 0, 0, 0);
                end
            end
        endfunction

        function void accept_byte(logic [7:0] b);
            case (phase)
                ucfp_pkg::PH_SYNC2: begin
                    if (b == ucfp_pkg::HDR_SECOND) begin
                        phase = ucfp_pkg::PH_FUNC;
                        sum = ucfp_pkg::SUM_INIT;
                    end else begin
                        phase = ucfp_pkg::PH_SYNC1;
                    end
                end
                ucfp_pkg::PH_FUNC: begin
                    func = b;
                    if (payload_len(b) == 0) begin
                        phase = ucfp_pkg::PH_SYNC1;
                        push(ucfp_pkg::EV_UNKNOWN_FN, 0, 0, 0, 1, 0, 0, 0);
                    end else begin
                        sum = sum + b;
                        phase = ucfp_pkg::PH_LEN;
                    end
                end
                ucfp_pkg::PH_LEN: begin
                    len_field = b;
                    sum = sum + b;
                    count = 0;
                    phase = ucfp_pkg::PH_DATA;
                end
                ucfp_pkg::PH_DATA: begin
                    if (count < ucfp_pkg::PAYLOAD_DEPTH_DEF) payload[count] = b;
                    sum = sum + b;
                    count = (count + 1) % 32;
                    if (count >= payload_len(func)) phase = ucfp_pkg::PH_CHECK;
                end
                ucfp_pkg::PH_CHECK: begin
                    phase = ucfp_pkg::PH_SYNC1;
                    decode_frame(b);
                end
                default: phase = (b == ucfp_pkg::HDR_FIRST) ? ucfp_pkg::PH_SYNC2
                                                            : ucfp_pkg::PH_SYNC1;
            endcase
        endfunction

        function void compare(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [3:0] ev, logic [39:0] data, logic last);
            frame_result_t e;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing pending: event_res %0d", ev);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            compare("event_res", e.ev, ev);
            compare("bank", e.bank, data[1:0]);
            compare("item_index", e.item_idx, data[5:2]);
            compare("value", e.value, data[21:6]);
            compare("last", e.last, last);
            compare("reply_needed", e.reply_needed, data[22]);
            compare("reply_code", e.reply_code, data[30:23]);
            compare("reply_check", e.reply_check, data[38:31]);
            compare("locked", e.locked, data[39]);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    frame_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    uplink_command_frame_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.accept_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic byte_q_t make_body(int n, int fill);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
        return q;
    endfunction

    // chk_xor of zero gives a correct checksum
    task automatic send_frame(input logic [7:0] fn, input logic [7:0] len_val,
                              input byte_q_t body, input logic [7:0] chk_xor);
        logic [7:0] sum;
        sum = ucfp_pkg::HDR_FIRST + ucfp_pkg::HDR_SECOND + fn + len_val;
        send_byte(ucfp_pkg::HDR_FIRST);
        send_byte(ucfp_pkg::HDR_SECOND);
        send_byte(fn);
        send_byte(len_val);
        foreach (body[i]) begin
            sum = sum + body[i];
            send_byte(body[i]);
        end
        send_byte(sum ^ chk_xor);
    endtask

    task automatic send_command(input logic [7:0] fn, input logic [7:0] cmd);
        send_frame(fn, 8'd1, make_body(1, cmd), 8'h00);
    endtask

    task automatic send_unknown_fn(input logic [7:0] fn);
        send_byte(ucfp_pkg::HDR_FIRST);
        send_byte(ucfp_pkg::HDR_SECOND);
        send_byte(fn);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic random_frame();
        int          kind;
        int          need;
        logic [7:0]  fn;
        logic [7:0]  cmd;
        logic [7:0]  len_val;
        logic [7:0]  chk_xor;
        logic [7:0]  set1_cmds[6];
        kind = $urandom_range(99);
        set1_cmds = '{ucfp_pkg::CMD_ACC_CAL, ucfp_pkg::CMD_GYRO_CAL, ucfp_pkg::CMD_MAG_CAL,
                      ucfp_pkg::CMD_LOCK, ucfp_pkg::CMD_UNLOCK, 8'h00};
        if (kind < 8) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end else if (kind < 12) begin
            send_byte(ucfp_pkg::HDR_FIRST);
            send_byte(8'($urandom_range(255)));
        end else if (kind < 17) begin
            do fn = 8'($urandom_range(255)); while (frame_scoreboard::payload_len(fn) != 0);
            send_unknown_fn(fn);
        end else begin
            kind = $urandom_range(99);
            if (kind < 40) fn = ucfp_pkg::FN_SET1;
            else if (kind < 60) fn = ucfp_pkg::FN_SET2;
            else if (kind < 80) fn = ucfp_pkg::FN_CONTROL;
            else fn = ucfp_pkg::FN_GAIN_LO + 8'($urandom_range(2));
            need = frame_scoreboard::payload_len(fn);
            len_val = ($urandom_range(99) < 8) ? 8'($urandom_range(255)) : 8'(need);
            chk_xor = ($urandom_range(99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
            if (fn == ucfp_pkg::FN_SET1) begin
                cmd = set1_cmds[$urandom_range(5)];
                if (cmd == 8'h00) cmd = 8'($urandom_range(255));
                send_frame(fn, len_val, make_body(1, cmd), chk_xor);
            end else if (fn == ucfp_pkg::FN_SET2) begin
                kind = $urandom_range(2);
                cmd = (kind == 0) ? ucfp_pkg::CMD_GAIN_REQ
                    : (kind == 1) ? ucfp_pkg::CMD_VER_REQ : 8'($urandom_range(255));
                send_frame(fn, len_val, make_body(1, cmd), chk_xor);
            end else begin
                send_frame(fn, len_val, make_body(need, -1), chk_xor);
            end
        end
    endtask

    initial begin
        int start;
        int pcts[4][2];
        pcts = '{'{0, 0}, '{79, 0}, '{0, 79}, '{32, 32}};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: noise, header mismatch, every command, unknown codes, extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ucfp_pkg::HDR_FIRST);
        send_byte(8'h55);
        send_command(ucfp_pkg::FN_SET1, ucfp_pkg::CMD_ACC_CAL);
        send_command(ucfp_pkg::FN_SET1, ucfp_pkg::CMD_GYRO_CAL);
        send_command(ucfp_pkg::FN_SET1, ucfp_pkg::CMD_MAG_CAL);
        send_command(ucfp_pkg::FN_SET1, ucfp_pkg::CMD_UNLOCK);
        send_command(ucfp_pkg::FN_SET1, 8'hFF);
        send_command(ucfp_pkg::FN_SET2, ucfp_pkg::CMD_GAIN_REQ);
        send_command(ucfp_pkg::FN_SET2, ucfp_pkg::CMD_VER_REQ);
        send_command(ucfp_pkg::FN_SET2, 8'h00);
        send_unknown_fn(8'h00);
        send_unknown_fn(8'hFF);
        send_unknown_fn(8'h13);
        send_frame(ucfp_pkg::FN_CONTROL, 8'd20, make_body(20, 8'hFF), 8'h00);
        send_frame(ucfp_pkg::FN_GAIN_LO, 8'd18, make_body(18, 8'h00), 8'h00);
        send_frame(ucfp_pkg::FN_GAIN_HI, 8'd18, make_body(18, 8'hFF), 8'h00);
        send_frame(ucfp_pkg::FN_GAIN_LO + 8'd1, 8'd18, make_body(18, -1), 8'h00);
        send_command(ucfp_pkg::FN_SET1, ucfp_pkg::CMD_LOCK);
        // bad checksum, then length mismatches
        send_frame(ucfp_pkg::FN_SET1, 8'd1, make_body(1, ucfp_pkg::CMD_UNLOCK), 8'h80);
        send_frame(ucfp_pkg::FN_CONTROL, 8'd18, make_body(20, -1), 8'h00);
        send_frame(ucfp_pkg::FN_SET2, 8'hFF, make_body(1, ucfp_pkg::CMD_VER_REQ), 8'h00);
        wait_for_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = pcts[p][0];
            recv_stall_pct = pcts[p][1];
            start = bytes_sent;
            while (bytes_sent - start < 12) random_frame();
            wait_for_results();
        end

        recv_stall_pct = 0;
        repeat (20) @(negedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
